// ===== hw/rtl/sltfd_pkg.sv =====
package sltfd_pkg;

  // Field widths
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned LEN_W  = 16;
  localparam int unsigned KIND_W = 2;
  localparam int unsigned CFG_W  = 16;
  localparam int unsigned IDX_W  = 2;

  // Register map
  localparam logic [IDX_W-1:0] CFG_SYNC_WORD  = 2'd0;
  localparam logic [IDX_W-1:0] CFG_MAX_LENGTH = 2'd1;

  localparam logic [CFG_W-1:0] SYNC_WORD_RST  = 16'h0000;
  localparam logic [CFG_W-1:0] MAX_LENGTH_RST = 16'd10240;

  // Smallest legal length: the two type bytes
  localparam logic [LEN_W-1:0] MIN_LENGTH = 16'd2;

  // Byte kinds on the result channel
  localparam logic [KIND_W-1:0] KIND_TYPE  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DATA  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CHECK = 2'd2;

  // Queue between front and back
  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
  localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef enum logic [7:0] {
    PH_HUNT  = 8'b0000_0001,
    PH_SYNC2 = 8'b0000_0010,
    PH_LENLO = 8'b0000_0100,
    PH_LENHI = 8'b0000_1000,
    PH_TYPLO = 8'b0001_0000,
    PH_TYPHI = 8'b0010_0000,
    PH_DATA  = 8'b0100_0000,
    PH_CHECK = 8'b1000_0000
  } phase_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic [KIND_W-1:0] kind;
    logic              type_index;
    logic              last;
    logic              frame_ok;
    logic [LEN_W-1:0]  frame_length;
  } rec_t;

  // Queue status seen by the front and back
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ===== hw/rtl/sync_length_type_frame_deframer.sv =====
// Channel | Direction | Handshake          | Payload
// input   | in        | in_valid/in_stall   | in_byte
// result  | out       | out_valid/out_stall | out_byte, out_byte_kind, out_type_index,
//         |           |                     | out_last, out_frame_ok, out_frame_length
// config  | in        | cfg_we              | cfg_index, cfg_wdata
//
// One byte is accepted per cycle while in_stall is low; the parser state updates
// in the cycle of acceptance. A result enters the queue at the accepting edge and
// moves to the output register when that register is empty or being taken.
// in_stall rises only when the four-entry queue is full, i.e. when out_stall has held
// the back end long enough; header bytes are also held then.
// rst_n is synchronous: parser hunts for the first sync byte, queue and output empty,
// sync_word clears and max_length returns to 10240.
module sync_length_type_frame_deframer (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration
  input  logic                          cfg_we,
  input  logic [sltfd_pkg::IDX_W-1:0]   cfg_index,
  input  logic [sltfd_pkg::CFG_W-1:0]   cfg_wdata,
  // received bytes
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [sltfd_pkg::BYTE_W-1:0]  in_byte,
  // frame beats
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [sltfd_pkg::BYTE_W-1:0]  out_byte,
  output logic [sltfd_pkg::KIND_W-1:0]  out_byte_kind,
  output logic                          out_type_index,
  output logic                          out_last,
  output logic                          out_frame_ok,
  output logic [sltfd_pkg::LEN_W-1:0]   out_frame_length
);

  logic                 in_take;
  logic                 push;
  logic                 pop;
  sltfd_pkg::rec_t      push_rec;
  sltfd_pkg::rec_t      pop_rec;
  sltfd_pkg::q_status_t status;

  // Hold the input side only when the queue cannot take another beat
  assign in_stall = status.full;
  assign in_take  = in_valid && !status.full;

  // Front: sync hunt, length check, classify and XOR the frame bytes
  sltfd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_take  (in_take),
    .in_byte  (in_byte),
    .push     (push),
    .push_rec (push_rec)
  );

  // Queue: decouple the parser from output back-pressure
  sltfd_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_rec(push_rec),
    .pop     (pop),
    .pop_rec (pop_rec),
    .status  (status)
  );

  // Back: registered result beat
  sltfd_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .status          (status),
    .pop_rec         (pop_rec),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_byte_kind   (out_byte_kind),
    .out_type_index  (out_type_index),
    .out_last        (out_last),
    .out_frame_ok    (out_frame_ok),
    .out_frame_length(out_frame_length)
  );

endmodule

// ===== hw/rtl/sltfd_front.sv =====
module sltfd_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [sltfd_pkg::IDX_W-1:0] cfg_index,
  input  logic [sltfd_pkg::CFG_W-1:0] cfg_wdata,
  input  logic                        in_take,
  input  logic [sltfd_pkg::BYTE_W-1:0] in_byte,
  output logic                        push,
  output sltfd_pkg::rec_t             push_rec
);

  logic [sltfd_pkg::CFG_W-1:0]  sync_word_r;
  logic [sltfd_pkg::CFG_W-1:0]  max_length_r;
  sltfd_pkg::phase_t            phase_r, phase_nxt;
  logic [sltfd_pkg::LEN_W-1:0]  remaining_r, remaining_nxt;
  logic [sltfd_pkg::BYTE_W-1:0] xor_r, xor_nxt;
  logic [sltfd_pkg::LEN_W-1:0]  length_r, length_nxt;
  logic [sltfd_pkg::LEN_W-1:0]  len_full;
  logic [sltfd_pkg::LEN_W-1:0]  rem_dec;
  logic                         first_hit;
  logic                         emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_word_r  <= sltfd_pkg::SYNC_WORD_RST;
      max_length_r <= sltfd_pkg::MAX_LENGTH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        sltfd_pkg::CFG_SYNC_WORD:  sync_word_r  <= cfg_wdata;
        sltfd_pkg::CFG_MAX_LENGTH: max_length_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign len_full  = {in_byte, length_r[sltfd_pkg::BYTE_W-1:0]};
  assign rem_dec   = remaining_r - 16'd1;
  assign first_hit = (in_byte == sync_word_r[7:0]);

  always_comb begin
    phase_nxt     = phase_r;
    remaining_nxt = remaining_r;
    xor_nxt       = xor_r;
    length_nxt    = length_r;
    emit          = 1'b0;
    push_rec.data         = in_byte;
    push_rec.kind         = sltfd_pkg::KIND_TYPE;
    push_rec.type_index   = 1'b0;
    push_rec.last         = 1'b0;
    push_rec.frame_ok     = 1'b0;
    push_rec.frame_length = length_r;
    case (phase_r)
      sltfd_pkg::PH_HUNT: begin
        phase_nxt = first_hit ? sltfd_pkg::PH_SYNC2 : sltfd_pkg::PH_HUNT;
      end
      sltfd_pkg::PH_SYNC2: begin
        if (in_byte == sync_word_r[15:8]) begin
          phase_nxt = sltfd_pkg::PH_LENLO;
        end else begin
          phase_nxt = first_hit ? sltfd_pkg::PH_SYNC2 : sltfd_pkg::PH_HUNT;
        end
      end
      sltfd_pkg::PH_LENLO: begin
        length_nxt = {8'h00, in_byte};
        phase_nxt  = sltfd_pkg::PH_LENHI;
      end
      sltfd_pkg::PH_LENHI: begin
        length_nxt = len_full;
        if (len_full > max_length_r || len_full < sltfd_pkg::MIN_LENGTH) begin
          // Drop the frame; retry this byte as a first sync byte
          phase_nxt = first_hit ? sltfd_pkg::PH_SYNC2 : sltfd_pkg::PH_HUNT;
        end else begin
          remaining_nxt = len_full - sltfd_pkg::MIN_LENGTH;
          xor_nxt       = '0;
          phase_nxt     = sltfd_pkg::PH_TYPLO;
        end
      end
      sltfd_pkg::PH_TYPLO: begin
        xor_nxt   = in_byte;
        phase_nxt = sltfd_pkg::PH_TYPHI;
        emit      = 1'b1;
      end
      sltfd_pkg::PH_TYPHI: begin
        xor_nxt   = xor_r ^ in_byte;
        phase_nxt = (remaining_r == '0) ? sltfd_pkg::PH_CHECK : sltfd_pkg::PH_DATA;
        emit      = 1'b1;
        push_rec.type_index = 1'b1;
      end
      sltfd_pkg::PH_DATA: begin
        xor_nxt       = xor_r ^ in_byte;
        remaining_nxt = rem_dec;
        if (rem_dec == '0) begin
          phase_nxt = sltfd_pkg::PH_CHECK;
        end
        emit          = 1'b1;
        push_rec.kind = sltfd_pkg::KIND_DATA;
      end
      sltfd_pkg::PH_CHECK: begin
        phase_nxt         = sltfd_pkg::PH_HUNT;
        emit              = 1'b1;
        push_rec.kind     = sltfd_pkg::KIND_CHECK;
        push_rec.last     = 1'b1;
        push_rec.frame_ok = (in_byte == xor_r);
      end
      default: begin
        phase_nxt = sltfd_pkg::PH_HUNT;
      end
    endcase
  end

  assign push = in_take && emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= sltfd_pkg::PH_HUNT;
      remaining_r <= '0;
      xor_r       <= '0;
      length_r    <= '0;
    end else if (in_take) begin
      phase_r     <= phase_nxt;
      remaining_r <= remaining_nxt;
      xor_r       <= xor_nxt;
      length_r    <= length_nxt;
    end
  end

endmodule

// ===== hw/rtl/sltfd_queue.sv =====
module sltfd_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  sltfd_pkg::rec_t       push_rec,
  input  logic                  pop,
  output sltfd_pkg::rec_t       pop_rec,
  output sltfd_pkg::q_status_t  status
);

  sltfd_pkg::rec_t                 mem_r [sltfd_pkg::Q_DEPTH];
  logic [sltfd_pkg::Q_PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [sltfd_pkg::Q_CNT_W-1:0]   count_r, count_nxt;

  assign status.full  = (count_r == sltfd_pkg::Q_CNT_W'(sltfd_pkg::Q_DEPTH));
  assign status.empty = (count_r == '0);
  assign pop_rec      = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

endmodule

// ===== hw/rtl/sltfd_back.sv =====
module sltfd_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  sltfd_pkg::q_status_t          status,
  input  sltfd_pkg::rec_t               pop_rec,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [sltfd_pkg::BYTE_W-1:0]  out_byte,
  output logic [sltfd_pkg::KIND_W-1:0]  out_byte_kind,
  output logic                          out_type_index,
  output logic                          out_last,
  output logic                          out_frame_ok,
  output logic [sltfd_pkg::LEN_W-1:0]   out_frame_length
);

  logic            valid_r;
  sltfd_pkg::rec_t rec_r;
  logic            load;

  // Refill the output register when it is empty or being taken
  assign load = !valid_r || !out_stall;
  assign pop  = load && !status.empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= !status.empty;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      rec_r <= pop_rec;
    end
  end

  assign out_valid        = valid_r;
  assign out_byte         = rec_r.data;
  assign out_byte_kind    = rec_r.kind;
  assign out_type_index   = rec_r.type_index;
  assign out_last         = rec_r.last;
  assign out_frame_ok     = rec_r.frame_ok;
  assign out_frame_length = rec_r.frame_length;

endmodule

// ===== hw/rtl/sltfd_checker.sv =====
module sltfd_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [sltfd_pkg::KIND_W-1:0]  out_byte_kind,
  input logic                          out_type_index,
  input logic                          out_last,
  input logic                          out_frame_ok,
  input logic [sltfd_pkg::LEN_W-1:0]   out_frame_length
);

  // A stalled beat stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("out_valid dropped while stalled");

  // Last marks the check byte and nothing else
  a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last == (out_byte_kind == sltfd_pkg::KIND_CHECK)))
    else $error("out_last does not match check byte kind");

  // Good flag and type index only where they mean something
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!out_frame_ok || out_last) &&
                  (!out_type_index || out_byte_kind == sltfd_pkg::KIND_TYPE))
    else $error("frame_ok or type_index set on wrong beat");

  // Any frame that yields beats passed the length check
  a_len_min: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_frame_length >= sltfd_pkg::MIN_LENGTH)
    else $error("beat from frame with length below two");

endmodule

bind sync_length_type_frame_deframer sltfd_checker u_sltfd_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_byte_kind   (out_byte_kind),
  .out_type_index  (out_type_index),
  .out_last        (out_last),
  .out_frame_ok    (out_frame_ok),
  .out_frame_length(out_frame_length)
);
